// ===== src/cbe_pkg.sv =====
// Package for the cubic Bezier easing core: table sizes, sample positions,
// sequencer state and step codes. No dependencies.
package cbe_pkg;

	localparam int TABLE_SIZE   = 11;
	localparam int IDX_W        = $clog2(TABLE_SIZE);
	localparam int NEWTON_STEPS = 4;
	localparam int BISECT_STEPS = 10;
	localparam int N_W          = $clog2(NEWTON_STEPS);
	localparam int B_W          = $clog2(BISECT_STEPS);
	localparam int DIV_W        = 40;
	localparam int DC_W         = $clog2(DIV_W);

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	// smallest integer slope with slope * 1000 >= 1.0 in Q16
	localparam logic signed [31:0] SLOPE_MIN = 32'sd66;
	localparam logic signed [31:0] OUT_MAX   = 32'sd262143;
	localparam logic signed [31:0] OUT_MIN   = -32'sd262144;

	localparam logic [1:0] REG_X1 = 2'd0;
	localparam logic [1:0] REG_Y1 = 2'd1;
	localparam logic [1:0] REG_X2 = 2'd2;
	localparam logic [1:0] REG_Y2 = 2'd3;

	typedef logic [16:0] tpos_tab_t [TABLE_SIZE];

	function automatic tpos_tab_t build_sample_t();
		tpos_tab_t tab;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tab[i] = 17'((i * 65536 + (TABLE_SIZE - 1) / 2) / (TABLE_SIZE - 1));
		end
		return tab;
	endfunction

	localparam tpos_tab_t SAMPLE_T = build_sample_t();

	typedef enum logic [3:0] {
		ST_REB,
		ST_IDLE,
		ST_SCAN,
		ST_INT_LO,
		ST_INT_HI,
		ST_INT_MUL,
		ST_INT_DIV,
		ST_EV_START,
		ST_EV_MUL,
		ST_EV_ADD,
		ST_DIV,
		ST_POST,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		K_TABLE,
		K_SLOPE0,
		K_NCURVE,
		K_NDIV,
		K_NSLOPE,
		K_BCURVE,
		K_YVAL,
		K_INTERP
	} kind_t;

endpackage

// ===== src/cubic_bezier_easing_core.sv =====
// Cubic Bezier easing core: sequencer, shared multiplier, radix-2 divider.
// Depends on cbe_pkg.
//
// Maps a progress value x (unsigned Q1.16) to the eased y (signed Q2.16) of a
// cubic Bezier curve from (0,0) to (1,1). One item is in flight at a time;
// in_stall is high while it is worked on. Inputs of 0 and 1 (and above 1)
// skip the search and raise out_valid with y equal to the clamped x.
// Otherwise the sample table is scanned, the first t is interpolated, and the
// answer follows after up to four Newton steps, up to ten bisection steps
// when the slope is small, or none when the slope is zero. The time is set
// by the 40-bit radix-2 divider behind each Newton step and interpolation,
// and by the shared multiplier, which takes a multiply state and an add state
// per Horner term. After reset and after each write of an x handle the table
// is rebuilt, 11 curve evaluations, during which no item is taken.
module cubic_bezier_easing_core import cbe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [16:0]        x_progress,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [18:0] eased_value,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [18:0]        cfg_data
);

	state_t state_q, state_d;
	kind_t  kind_q;

	logic [16:0]        hx1_q, hx2_q;
	logic signed [18:0] hy1_q, hy2_q;
	logic [16:0]        table_q [TABLE_SIZE];

	logic [16:0]        x_q, t_q, a_q, b_q, tab_lo_q, den_q;
	logic [IDX_W-1:0]   k_q, ri_q;
	logic [N_W-1:0]     n_q;
	logic [B_W-1:0]     i_q;
	logic [1:0]         step_q;
	logic signed [31:0] acc_q, s_q;
	logic signed [49:0] prod_q;
	logic [DIV_W-1:0]   dvd_q;
	logic [31:0]        rem_q, dsr_q;
	logic               neg_q;
	logic [DC_W-1:0]    dcnt_q;
	logic signed [18:0] y_q, out_q;
	logic               out_valid_q;

	logic               in_accept, out_load, cfg_x_wr;
	logic [16:0]        cfg_xc, xin_c;
	logic               endp;
	logic signed [31:0] px1, px2, py1, py2, p1, p2, ca, cb, cc, c0, addend, acc_rnd;
	logic               is_slope;
	logic [1:0]         last_step;
	logic [16:0]        span, lo_t, hi_t, tab_rd, mul_src, cur_init, cur_n, a_n, b_n;
	logic signed [17:0] mul_b, den_d;
	logic [IDX_W-1:0]   k_nx, rd_addr;
	logic               scan_go, den_pos;
	logic [49:0]        prod_mag;
	logic [33:0]        rnd_mag;
	logic signed [31:0] diff_d;
	logic               d_neg, d_pos, s_neg;
	logic [31:0]        d_mag, s_mag;
	logic [32:0]        rem_sh, trial;
	logic               q_bit;
	logic signed [41:0] q_s, t_newt;
	logic [16:0]        t_newt_c, t_int_c, tab_val;
	logic [40:0]        t_int;
	logic signed [18:0] y_sat;
	logic               last_n, last_i;

	assign cfg_x_wr = cfg_wr_en && (cfg_index == REG_X1 || cfg_index == REG_X2);
	assign cfg_xc   = (cfg_data[16:0] > ONE_Q16) ? ONE_Q16 : cfg_data[16:0];
	assign xin_c    = (x_progress > ONE_Q16) ? ONE_Q16 : x_progress;
	assign endp     = (xin_c == 17'd0) || (xin_c == ONE_Q16);

	assign px1 = signed'(32'(hx1_q));
	assign px2 = signed'(32'(hx2_q));
	assign py1 = 32'(hy1_q);
	assign py2 = 32'(hy2_q);
	assign p1  = (kind_q == K_YVAL) ? py1 : px1;
	assign p2  = (kind_q == K_YVAL) ? py2 : px2;
	assign ca  = 32'sd65536 + 32'sd3 * p1 - 32'sd3 * p2;
	assign cb  = 32'sd3 * p2 - 32'sd6 * p1;
	assign cc  = 32'sd3 * p1;

	assign is_slope  = (kind_q == K_SLOPE0) || (kind_q == K_NSLOPE);
	assign c0        = is_slope ? 32'sd3 * ca : ca;
	assign last_step = is_slope ? 2'd1 : 2'd2;

	always_comb begin
		case (step_q)
			2'd0:    addend = is_slope ? 32'sd2 * cb : cb;
			2'd1:    addend = cc;
			default: addend = 32'sd0;
		endcase
	end

	assign k_nx     = IDX_W'(k_q + 1'b1);
	assign lo_t     = SAMPLE_T[k_q];
	assign hi_t     = SAMPLE_T[k_nx];
	assign span     = hi_t - lo_t;
	assign cur_init = 17'((18'(lo_t) + 18'(hi_t)) >> 1);
	assign mul_src  = (state_q == ST_INT_MUL) ? span : t_q;
	assign mul_b    = signed'({1'b0, mul_src});

	assign rd_addr = (state_q == ST_INT_HI) ? k_nx : k_q;
	assign tab_rd  = table_q[rd_addr];
	assign scan_go = (k_q != IDX_W'(TABLE_SIZE - 1)) && (tab_rd <= x_q);
	assign den_d   = signed'({1'b0, tab_rd}) - signed'({1'b0, tab_lo_q});
	assign den_pos = !den_d[17] && (den_d != 18'sd0);

	assign prod_mag = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
	assign rnd_mag  = 34'((prod_mag + 50'd32768) >> 16);
	assign acc_rnd  = prod_q[49] ? -signed'(32'(rnd_mag)) : signed'(32'(rnd_mag));

	assign diff_d = acc_q - signed'(32'(x_q));
	assign d_neg  = diff_d[31];
	assign d_pos  = !d_neg && (diff_d != 32'sd0);
	assign d_mag  = d_neg ? 32'(-diff_d) : 32'(diff_d);
	assign s_neg  = s_q[31];
	assign s_mag  = s_neg ? 32'(-s_q) : 32'(s_q);

	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign trial  = rem_sh - {1'b0, dsr_q};
	assign q_bit  = !trial[32];

	assign q_s      = neg_q ? -signed'({2'b00, dvd_q}) : signed'({2'b00, dvd_q});
	assign t_newt   = signed'(42'(t_q)) - q_s;
	assign t_newt_c = t_newt[41] ? 17'd0 :
		(t_newt > signed'(42'(ONE_Q16)) ? ONE_Q16 : t_newt[16:0]);
	assign t_int    = 41'(lo_t) + 41'(dvd_q);
	assign t_int_c  = (t_int > 41'(ONE_Q16)) ? ONE_Q16 : t_int[16:0];

	assign tab_val = acc_q[31] ? 17'd0 :
		(acc_q > signed'(32'(ONE_Q16)) ? ONE_Q16 : acc_q[16:0]);
	assign y_sat   = (acc_q > OUT_MAX) ? 19'(OUT_MAX) :
		((acc_q < OUT_MIN) ? 19'(OUT_MIN) : acc_q[18:0]);

	assign a_n   = d_pos ? a_q : t_q;
	assign b_n   = d_pos ? t_q : b_q;
	assign cur_n = 17'((18'(a_n) + 18'(b_n)) >> 1);

	assign last_n = (n_q == N_W'(NEWTON_STEPS - 1));
	assign last_i = (i_q == B_W'(BISECT_STEPS - 1));

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		in_accept = in_valid && (state_q == ST_IDLE);
		out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_REB:      state_d = ST_EV_START;
			ST_IDLE:     if (in_accept) state_d = endp ? ST_DONE : ST_SCAN;
			ST_SCAN:     if (!scan_go) state_d = ST_INT_LO;
			ST_INT_LO:   state_d = ST_INT_HI;
			ST_INT_HI:   state_d = den_pos ? ST_INT_MUL : ST_EV_START;
			ST_INT_MUL:  state_d = ST_INT_DIV;
			ST_INT_DIV:  state_d = ST_DIV;
			ST_EV_START: state_d = ST_EV_MUL;
			ST_EV_MUL:   state_d = ST_EV_ADD;
			ST_EV_ADD:   if (step_q == last_step) state_d = ST_POST;
				else state_d = ST_EV_MUL;
			ST_DIV:      if (dcnt_q == DC_W'(DIV_W - 1)) state_d = ST_POST;
			ST_POST: begin
				case (kind_q)
					K_TABLE:  state_d = (ri_q == IDX_W'(TABLE_SIZE - 1)) ? ST_IDLE : ST_REB;
					K_YVAL:   state_d = ST_DONE;
					K_NCURVE: state_d = ST_DIV;
					default:  state_d = ST_EV_START;
				endcase
			end
			ST_DONE:     if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
		if (cfg_x_wr) state_d = ST_REB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_REB;
			ri_q        <= '0;
			out_valid_q <= 1'b0;
			hx1_q       <= 17'd0;
			hy1_q       <= 19'sd0;
			hx2_q       <= ONE_Q16;
			hy2_q       <= 19'sd65536;
		end else begin
			state_q <= state_d;
			if (cfg_x_wr) begin
				ri_q <= '0;
			end else if (state_q == ST_POST && kind_q == K_TABLE &&
					ri_q != IDX_W'(TABLE_SIZE - 1)) begin
				ri_q <= IDX_W'(ri_q + 1'b1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_X1:  hx1_q <= cfg_xc;
					REG_Y1:  hy1_q <= signed'(cfg_data);
					REG_X2:  hx2_q <= cfg_xc;
					REG_Y2:  hy2_q <= signed'(cfg_data);
					default: hx1_q <= hx1_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= y_q;
		case (state_q)
			ST_REB: begin
				t_q    <= SAMPLE_T[ri_q];
				kind_q <= K_TABLE;
			end
			ST_IDLE: begin
				if (in_accept) begin
					x_q <= xin_c;
					y_q <= signed'(19'(xin_c));
					k_q <= IDX_W'(1);
				end
			end
			ST_SCAN: k_q <= scan_go ? k_nx : IDX_W'(k_q - 1'b1);
			ST_INT_LO: tab_lo_q <= tab_rd;
			ST_INT_HI: begin
				acc_q <= signed'(32'(x_q - tab_lo_q));
				den_q <= den_d[16:0];
				if (!den_pos) begin
					t_q    <= lo_t;
					kind_q <= K_SLOPE0;
				end
			end
			ST_INT_MUL: prod_q <= acc_q * mul_b;
			ST_INT_DIV: begin
				dvd_q  <= prod_q[DIV_W-1:0];
				dsr_q  <= 32'(den_q);
				rem_q  <= '0;
				dcnt_q <= '0;
				neg_q  <= 1'b0;
				kind_q <= K_INTERP;
			end
			ST_EV_START: begin
				acc_q  <= c0;
				step_q <= 2'd0;
			end
			ST_EV_MUL: prod_q <= acc_q * mul_b;
			ST_EV_ADD: begin
				acc_q  <= acc_rnd + addend;
				step_q <= 2'(step_q + 1'b1);
			end
			ST_DIV: begin
				rem_q  <= q_bit ? trial[31:0] : rem_sh[31:0];
				dvd_q  <= {dvd_q[DIV_W-2:0], q_bit};
				dcnt_q <= DC_W'(dcnt_q + 1'b1);
			end
			ST_POST: begin
				case (kind_q)
					K_TABLE: table_q[ri_q] <= tab_val;
					K_SLOPE0: begin
						s_q <= acc_q;
						if (acc_q >= SLOPE_MIN) begin
							n_q    <= '0;
							kind_q <= K_NCURVE;
						end else if (acc_q != 32'sd0) begin
							a_q    <= lo_t;
							b_q    <= hi_t;
							i_q    <= '0;
							t_q    <= cur_init;
							kind_q <= K_BCURVE;
						end else begin
							kind_q <= K_YVAL;
						end
					end
					K_NCURVE: begin
						dvd_q  <= {d_mag[23:0], 16'd0};
						dsr_q  <= s_mag;
						rem_q  <= '0;
						dcnt_q <= '0;
						neg_q  <= d_neg ^ s_neg;
						kind_q <= K_NDIV;
					end
					K_NDIV: begin
						t_q    <= t_newt_c;
						n_q    <= N_W'(n_q + 1'b1);
						kind_q <= last_n ? K_YVAL : K_NSLOPE;
					end
					K_NSLOPE: begin
						s_q    <= acc_q;
						kind_q <= (acc_q == 32'sd0) ? K_YVAL : K_NCURVE;
					end
					K_BCURVE: begin
						if (diff_d == 32'sd0 || last_i) begin
							kind_q <= K_YVAL;
						end else begin
							a_q <= a_n;
							b_q <= b_n;
							t_q <= cur_n;
							i_q <= B_W'(i_q + 1'b1);
						end
					end
					K_YVAL: y_q <= y_sat;
					K_INTERP: begin
						t_q    <= t_int_c;
						kind_q <= K_SLOPE0;
					end
					default: kind_q <= K_YVAL;
				endcase
			end
			default: step_q <= step_q;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign eased_value = out_q;

`ifndef SYNTHESIS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dsr_q != 32'd0))
		else $error("divider running with a zero divisor");

	a_table_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (table_q[0] == 17'd0))
		else $error("first table sample is not zero");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EV_MUL) |-> (t_q <= ONE_Q16))
		else $error("curve parameter out of range");
`endif

endmodule
